// File: hw/rtl/fqms_pkg.sv
// Shared types, constants and helpers for the fuzzy query match scorer.
// No dependencies; used by fqms_track and fuzzy_query_match_scorer.
`timescale 1ns / 1ps
`default_nettype none

package fqms_pkg;

    // Default number of window cells (longest usable query)
    localparam int QUERY_MAX_DEF = 8;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_QUERY_LENGTH = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_QUERY_CHARS  = 1'd1;

    // Score values
    localparam logic [7:0] SCORE_SUBSTR       = 8'd100;
    localparam logic [7:0] PREFIX_BONUS       = 8'd50;
    localparam logic [7:0] SCORE_PREFIX       = SCORE_SUBSTR + PREFIX_BONUS;
    localparam logic [7:0] SCORE_EMPTY_QUERY  = 8'd1;
    localparam logic [7:0] STEP_CONT          = 8'd5;
    localparam logic [7:0] STEP_GAP           = 8'd3;
    localparam logic [7:0] BOUNDARY_BONUS     = 8'd10;
    localparam logic [7:0] RUN_SCORE_MAX      = 8'd127;

    // Characters of interest
    localparam logic [7:0] CHAR_SPACE      = 8'h20;
    localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CHAR_UP_A       = 8'h41;
    localparam logic [7:0] CHAR_UP_Z       = 8'h5A;
    localparam logic [7:0] CHAR_LO_A       = 8'h61;
    localparam logic [7:0] CHAR_LO_Z       = 8'h7A;
    localparam logic [7:0] CASE_OFFSET     = 8'h20;

    // Saturation limit of the character counter
    localparam logic [3:0] SEEN_MAX = 4'd15;

    typedef enum logic [2:0] {
        KIND_NONE        = 3'd0,
        KIND_FUZZY       = 3'd1,
        KIND_SUBSTR      = 3'd2,
        KIND_PREFIX      = 3'd3,
        KIND_EMPTY_QUERY = 3'd4
    } t_kind;

    typedef struct packed {
        logic [7:0] score;
        t_kind      kind;
    } t_result;

    function automatic logic is_upper(input logic [7:0] c);
        return (c >= CHAR_UP_A) && (c <= CHAR_UP_Z);
    endfunction

    function automatic logic is_lower(input logic [7:0] c);
        return (c >= CHAR_LO_A) && (c <= CHAR_LO_Z);
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return is_upper(c) ? (c + CASE_OFFSET) : c;
    endfunction

    // Lowercased query byte at a position, first character in the lowest byte
    function automatic logic [7:0] query_char(input logic [63:0] chars,
                                              input logic [2:0]  idx);
        return to_lower(chars[{idx, 3'b000} +: 8]);
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/fqms_cell.sv
// One window cell: holds a lowercased text character, hands it to its
// neighbor on every character word and compares its next value with one query char.
// Depends on nothing but the clock and reset.
`timescale 1ns / 1ps
`default_nettype none

module fqms_cell (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_shift,       // character word taken
    input  wire logic       i_clear,       // empty-text word taken
    input  wire logic [7:0] i_char_in,     // value from the left neighbor
    input  wire logic [7:0] i_query_char,  // query char aligned to this cell
    input  wire logic       i_use,         // cell lies inside the query length
    output logic      [7:0] o_char,
    output logic            o_hit
);

    logic [7:0] r_char;
    logic [7:0] n_char;

    // next content of the cell
    always_comb begin
        if (i_clear) begin
            n_char = 8'd0;
        end else if (i_shift) begin
            n_char = i_char_in;
        end else begin
            n_char = r_char;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_char <= 8'd0;
        end else begin
            r_char <= n_char;
        end
    end

    // compare against the window as it stands after this word
    assign o_hit  = !i_use || (n_char == i_query_char);
    assign o_char = r_char;

endmodule

`default_nettype wire

// File: hw/rtl/fqms_track.sv
// Per-text tracking: character count, substring and prefix flags, and the
// subsequence scorer; forms the result of a finished text.
// Depends on fqms_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fqms_track (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_take,        // character word taken
    input  wire logic        i_clear,       // empty-text word taken
    input  wire logic        i_first,       // first character of a text
    input  wire logic [7:0]  i_raw,
    input  wire logic [7:0]  i_low,
    input  wire logic [3:0]  i_qlen,        // clamped query length
    input  wire logic [63:0] i_query_chars,
    input  wire logic        i_window_hit,  // all used cells match
    output fqms_pkg::t_result o_result
);

    logic [3:0] r_seen, n_seen, b_seen;
    logic       r_sub, n_sub, b_sub;
    logic       r_pre, n_pre, b_pre;
    logic [3:0] r_mc, n_mc, b_mc;
    logic [6:0] r_run, n_run, b_run;
    logic       r_pm, n_pm, b_pm;
    logic [7:0] r_prev, n_prev, b_prev;

    logic       hit;
    logic       boundary;
    logic [7:0] qc;
    logic [7:0] sum;

    // state as seen by this word: cleared at the first character
    always_comb begin
        b_seen = i_first ? 4'd0 : r_seen;
        b_sub  = i_first ? 1'b0 : r_sub;
        b_pre  = i_first ? 1'b0 : r_pre;
        b_mc   = i_first ? 4'd0 : r_mc;
        b_run  = i_first ? 7'd0 : r_run;
        b_pm   = i_first ? 1'b0 : r_pm;
        b_prev = i_first ? 8'd0 : r_prev;
    end

    // subsequence step
    always_comb begin
        qc       = fqms_pkg::query_char(i_query_chars, b_mc[2:0]);
        boundary = (b_seen == 4'd0) || (b_prev == fqms_pkg::CHAR_SPACE) ||
                   (b_prev == fqms_pkg::CHAR_UNDERSCORE) ||
                   (fqms_pkg::is_lower(b_prev) && fqms_pkg::is_upper(i_raw));
        sum      = {1'b0, b_run} + (b_pm ? fqms_pkg::STEP_CONT : fqms_pkg::STEP_GAP) +
                   (boundary ? fqms_pkg::BOUNDARY_BONUS : 8'd0);
        n_mc  = b_mc;
        n_run = b_run;
        n_pm  = b_pm;
        if ((i_qlen != 4'd0) && (b_mc < i_qlen)) begin
            if (i_low == qc) begin
                n_run = (sum > fqms_pkg::RUN_SCORE_MAX) ? fqms_pkg::RUN_SCORE_MAX[6:0]
                                                        : sum[6:0];
                n_pm  = 1'b1;
                n_mc  = b_mc + 4'd1;
            end else begin
                n_pm  = 1'b0;
            end
        end
    end

    // counter and contiguous match flags
    always_comb begin
        n_seen = (b_seen < fqms_pkg::SEEN_MAX) ? (b_seen + 4'd1) : b_seen;
        n_prev = i_raw;
        hit    = (i_qlen != 4'd0) && (n_seen >= i_qlen) && i_window_hit;
        n_sub  = b_sub || hit;
        n_pre  = b_pre || (hit && (n_seen == i_qlen));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_seen <= 4'd0;
            r_sub  <= 1'b0;
            r_pre  <= 1'b0;
            r_mc   <= 4'd0;
            r_run  <= 7'd0;
            r_pm   <= 1'b0;
            r_prev <= 8'd0;
        end else if (i_take) begin
            r_seen <= n_seen;
            r_sub  <= n_sub;
            r_pre  <= n_pre;
            r_mc   <= n_mc;
            r_run  <= n_run;
            r_pm   <= n_pm;
            r_prev <= n_prev;
        end
    end

    // result of the text, valid when the word ends it
    always_comb begin
        o_result.score = 8'd0;
        o_result.kind  = fqms_pkg::KIND_NONE;
        if (i_qlen == 4'd0) begin
            o_result.score = fqms_pkg::SCORE_EMPTY_QUERY;
            o_result.kind  = fqms_pkg::KIND_EMPTY_QUERY;
        end else if (i_clear) begin
            o_result.score = 8'd0;
            o_result.kind  = fqms_pkg::KIND_NONE;
        end else if (n_sub) begin
            if (n_pre) begin
                o_result.score = fqms_pkg::SCORE_PREFIX;
                o_result.kind  = fqms_pkg::KIND_PREFIX;
            end else begin
                o_result.score = fqms_pkg::SCORE_SUBSTR;
                o_result.kind  = fqms_pkg::KIND_SUBSTR;
            end
        end else if (n_mc >= i_qlen) begin
            o_result.score = {1'b0, n_run};
            o_result.kind  = fqms_pkg::KIND_FUZZY;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/fuzzy_query_match_scorer.sv
// Fuzzy query match scorer: query registers, a row of window cells, the
// per-text tracker and an output register with a skid stage.
// Depends on fqms_pkg, fqms_cell and fqms_track.
//
// Usage:
//   Write query_length (index 0) and query_chars (index 1, first char in the
//   lowest byte) through i_cfg_we / i_cfg_index / i_cfg_data while idle.
//   Stream text characters on the input channel (i_valid / o_stall), one per
//   word, marking the first and last character; an empty text is one word
//   with i_empty_text set. A word is taken when i_valid is high and o_stall
//   is low.
//   Each last-character or empty-text word yields one score word on the
//   output channel (o_valid / i_stall), registered after it is taken.
//   Throughput is one character per cycle while o_stall is low: the window
//   is a chain of QUERY_MAX cells that shift and compare in the same cycle,
//   and the subsequence step is one add and compare.
//   When the receiver stalls, the held result stays on the outputs and one
//   further result is caught in the skid stage; o_stall then rises until
//   the skid stage drains.
//   Reset clears the query registers (empty query), the window and all
//   per-text state; no result is pending after reset.
`timescale 1ns / 1ps
`default_nettype none

module fuzzy_query_match_scorer #(
    parameter int QUERY_MAX = fqms_pkg::QUERY_MAX_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // configuration
    input  wire logic                             i_cfg_we,
    input  wire logic [fqms_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [63:0]                      i_cfg_data,
    // input channel
    input  wire logic                             i_valid,
    output logic                                  o_stall,
    input  wire logic [7:0]                       i_text_char,
    input  wire logic                             i_first_char,
    input  wire logic                             i_last_char,
    input  wire logic                             i_empty_text,
    // output channel
    output logic                                  o_valid,
    input  wire logic                             i_stall,
    output logic [7:0]                            o_score,
    output logic [2:0]                            o_match_kind
);

    logic [3:0]  r_query_length;
    logic [63:0] r_query_chars;

    logic        accept;
    logic        take;
    logic        clear;
    logic        first;
    logic [7:0]  low;
    logic [3:0]  qlen;

    logic [7:0]           w_char [QUERY_MAX];
    logic [QUERY_MAX-1:0] w_hit;

    fqms_pkg::t_result res;
    fqms_pkg::t_result r_out;
    fqms_pkg::t_result r_skid;
    logic              r_out_valid;
    logic              r_skid_valid;
    logic              res_valid;
    logic              out_free;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_query_length <= 4'd0;
            r_query_chars  <= 64'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                fqms_pkg::CFG_QUERY_LENGTH: r_query_length <= i_cfg_data[3:0];
                fqms_pkg::CFG_QUERY_CHARS:  r_query_chars  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // word decode
    assign accept = i_valid && !o_stall;
    assign take   = accept && !i_empty_text;
    assign clear  = accept && i_empty_text;
    assign first  = i_first_char;
    assign low    = fqms_pkg::to_lower(i_text_char);
    assign qlen   = (r_query_length > 4'(QUERY_MAX)) ? 4'(QUERY_MAX) : r_query_length;

    // window: cell 0 takes the new char, cell k the char of cell k-1 (zero on a first char)
    for (genvar k = 0; k < QUERY_MAX; k++) begin : g_cell
        logic [7:0] char_in;
        logic [3:0] qidx;

        if (k == 0) begin : g_head
            assign char_in = low;
        end else begin : g_body
            assign char_in = first ? 8'd0 : w_char[k-1];
        end

        // cell k holds the char matched by query position qlen-1-k
        assign qidx = qlen - 4'(k) - 4'd1;

        fqms_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_shift      (take),
            .i_clear      (clear),
            .i_char_in    (char_in),
            .i_query_char (fqms_pkg::query_char(r_query_chars, qidx[2:0])),
            .i_use        (4'(k) < qlen),
            .o_char       (w_char[k]),
            .o_hit        (w_hit[k])
        );
    end

    fqms_track u_track (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (take),
        .i_clear       (clear),
        .i_first       (first),
        .i_raw         (i_text_char),
        .i_low         (low),
        .i_qlen        (qlen),
        .i_query_chars (r_query_chars),
        .i_window_hit  (&w_hit),
        .o_result      (res)
    );

    // output register with skid stage
    assign res_valid = accept && (i_empty_text || i_last_char);
    assign out_free  = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid  <= r_skid_valid || res_valid;
            r_skid_valid <= 1'b0;
        end else if (res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : res;
        end else if (res_valid) begin
            r_skid <= res;
        end
    end

    assign o_stall      = r_skid_valid;
    assign o_valid      = r_out_valid;
    assign o_score      = r_out.score;
    assign o_match_kind = r_out.kind;

endmodule

`default_nettype wire
